FILE: design/alubcd_pkg.sv
package alubcd_pkg;

	// Operation codes; codes 13 to 15 act as no operation
	typedef enum logic [3:0] {
		OP_ADC = 4'd0,
		OP_SBC = 4'd1,
		OP_AND = 4'd2,
		OP_OR  = 4'd3,
		OP_XOR = 4'd4,
		OP_CMP = 4'd5,
		OP_BIT = 4'd6,
		OP_ASL = 4'd7,
		OP_LSR = 4'd8,
		OP_ROL = 4'd9,
		OP_ROR = 4'd10,
		OP_INC = 4'd11,
		OP_DEC = 4'd12
	} op_t;

	localparam int unsigned OP_W   = 4;
	localparam int unsigned DATA_W = 8;

	// BCD adjust constants
	localparam logic [4:0] BCD_DIGIT_MAX  = 5'd10;
	localparam logic [4:0] BCD_DIGIT_CY   = 5'h10;
	localparam logic [3:0] BCD_SUB_ADJ    = 4'd6;
	localparam logic [8:0] BCD_HI_LIMIT   = 9'h09f;
	localparam logic [9:0] BCD_HI_ADJ     = 10'h060;

endpackage

FILE: design/alubcd_in_if.sv
interface alubcd_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic [7:0] reg_value;
	logic [7:0] operand;
	logic       carry_in;
	logic       overflow_in;
	logic       decimal_mode;

	modport source (
		output valid, req_type, reg_value, operand, carry_in, overflow_in, decimal_mode,
		input  ready
	);
	modport sink (
		input  valid, req_type, reg_value, operand, carry_in, overflow_in, decimal_mode,
		output ready
	);
endinterface

FILE: design/alubcd_out_if.sv
interface alubcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic       writes_back;
	logic       carry_out;
	logic       overflow_out;
	logic       negative_out;
	logic       zero_out;

	modport source (
		output valid, result, writes_back, carry_out, overflow_out, negative_out, zero_out,
		input  ready
	);
	modport sink (
		input  valid, result, writes_back, carry_out, overflow_out, negative_out, zero_out,
		output ready
	);
endinterface

FILE: design/eight_bit_cpu_alu_with_bcd.sv
// Channel  Direction  Payload
// req      in         req_type, reg_value, operand, carry_in, overflow_in, decimal_mode
// rsp      out        result, writes_back, carry_out, overflow_out, negative_out, zero_out
//
// Three register stages: low digit and binary sums, high digit sums and logic/shift
// results, then decimal adjust, flag merge and the output register.
// One item per cycle while rsp is ready; each item passes through all stages to rsp.
// arst_n clears the stage valid bits only; payload registers are not reset.
// Each stage advances when its successor is empty or moving, so a stall on rsp
// holds every stage in place while empty stages still fill.
module eight_bit_cpu_alu_with_bcd (
	input  logic         clk,
	input  logic         arst_n,
	alubcd_in_if.sink    req,
	alubcd_out_if.source rsp
);
	import alubcd_pkg::*;

	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] m;
		logic       c;
		logic       v;
		logic       dec;
		logic [8:0] sum9;
		logic [4:0] adc_lo;
		logic [8:0] diff9;
		logic [8:0] cmp9;
		logic [3:0] sbc_lo;
		logic       sbc_brw;
		logic [4:0] sbc_hi0;
	} stg1_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] m;
		logic       dec;
		logic [8:0] sum9;
		logic [8:0] adc_s9;
		logic [8:0] diff9;
		logic [7:0] sbc_dec;
		logic [7:0] misc_res;
		logic       misc_wb;
		logic       misc_cy;
		logic       misc_ov;
		logic       misc_n;
		logic       misc_z;
	} stg2_t;

	typedef struct packed {
		logic [7:0] result;
		logic       wb;
		logic       cy;
		logic       ov;
		logic       n;
		logic       z;
	} stg3_t;

	logic  vld_s1, vld_s2, vld_s3;
	stg1_t d_s1;
	stg2_t d_s2;
	stg3_t d_s3;
	stg1_t nxt1;
	stg2_t nxt2;
	stg3_t nxt3;
	logic  adv1, adv2, adv3;

	// Advance a stage when the one after it is empty or moving
	assign adv3      = !vld_s3 || rsp.ready;
	assign adv2      = !vld_s2 || adv3;
	assign adv1      = !vld_s1 || adv2;
	assign req.ready = adv1;

	// Stage 1: low digit and binary sums
	always_comb begin
		logic [4:0] lo0;
		logic [4:0] slo0;
		nxt1.op      = op_t'(req.req_type);
		nxt1.a       = req.reg_value;
		nxt1.m       = req.operand;
		nxt1.c       = req.carry_in;
		nxt1.v       = req.overflow_in;
		nxt1.dec     = req.decimal_mode;
		nxt1.sum9    = {1'b0, req.reg_value} + {1'b0, req.operand} + {8'b0, req.carry_in};
		nxt1.diff9   = {1'b0, req.reg_value} - {1'b0, req.operand} - 9'd1
			+ {8'b0, req.carry_in};
		nxt1.cmp9    = {1'b0, req.reg_value} - {1'b0, req.operand};
		lo0          = {1'b0, req.reg_value[3:0]} + {1'b0, req.operand[3:0]}
			+ {4'b0, req.carry_in};
		nxt1.adc_lo  = (lo0 >= BCD_DIGIT_MAX) ? ((lo0 - BCD_DIGIT_MAX) | BCD_DIGIT_CY) : lo0;
		slo0         = {1'b0, req.reg_value[3:0]} - {1'b0, req.operand[3:0]} - 5'd1
			+ {4'b0, req.carry_in};
		nxt1.sbc_brw = slo0[4];
		nxt1.sbc_lo  = slo0[4] ? (slo0[3:0] - BCD_SUB_ADJ) : slo0[3:0];
		nxt1.sbc_hi0 = {1'b0, req.reg_value[7:4]} - {1'b0, req.operand[7:4]};
	end

	// Stage 2: high digit sums, logic and shift results
	always_comb begin
		logic [4:0] hi1;
		logic [3:0] hi;
		nxt2.op       = d_s1.op;
		nxt2.a        = d_s1.a;
		nxt2.m        = d_s1.m;
		nxt2.dec      = d_s1.dec;
		nxt2.sum9     = d_s1.sum9;
		nxt2.diff9    = d_s1.diff9;
		nxt2.adc_s9   = {4'b0, d_s1.adc_lo} + {1'b0, d_s1.a[7:4], 4'b0}
			+ {1'b0, d_s1.m[7:4], 4'b0};
		hi1           = d_s1.sbc_hi0 - {4'b0, d_s1.sbc_brw};
		hi            = hi1[4] ? (hi1[3:0] - BCD_SUB_ADJ) : hi1[3:0];
		nxt2.sbc_dec  = {hi, d_s1.sbc_lo};

		nxt2.misc_res = d_s1.a;
		nxt2.misc_wb  = 1'b1;
		nxt2.misc_cy  = d_s1.c;
		nxt2.misc_ov  = d_s1.v;
		case (d_s1.op)
			OP_AND: nxt2.misc_res = d_s1.a & d_s1.m;
			OP_OR:  nxt2.misc_res = d_s1.a | d_s1.m;
			OP_XOR: nxt2.misc_res = d_s1.a ^ d_s1.m;
			OP_CMP: begin
				nxt2.misc_wb = 1'b0;
				nxt2.misc_cy = !d_s1.cmp9[8];
			end
			OP_BIT: begin
				nxt2.misc_wb = 1'b0;
				nxt2.misc_ov = d_s1.m[6];
			end
			OP_ASL: begin
				nxt2.misc_cy  = d_s1.m[7];
				nxt2.misc_res = {d_s1.m[6:0], 1'b0};
			end
			OP_LSR: begin
				nxt2.misc_cy  = d_s1.m[0];
				nxt2.misc_res = {1'b0, d_s1.m[7:1]};
			end
			OP_ROL: begin
				nxt2.misc_cy  = d_s1.m[7];
				nxt2.misc_res = {d_s1.m[6:0], d_s1.c};
			end
			OP_ROR: begin
				nxt2.misc_cy  = d_s1.m[0];
				nxt2.misc_res = {d_s1.c, d_s1.m[7:1]};
			end
			OP_INC: nxt2.misc_res = d_s1.m + 8'd1;
			OP_DEC: nxt2.misc_res = d_s1.m - 8'd1;
			default: nxt2.misc_wb = 1'b0;
		endcase

		// Take negative and zero from the difference or the bit test where needed
		case (d_s1.op)
			OP_CMP: begin
				nxt2.misc_n = d_s1.cmp9[7];
				nxt2.misc_z = (d_s1.cmp9[7:0] == 8'd0);
			end
			OP_BIT: begin
				nxt2.misc_n = d_s1.m[7];
				nxt2.misc_z = ((d_s1.m & d_s1.a) == 8'd0);
			end
			default: begin
				nxt2.misc_n = nxt2.misc_res[7];
				nxt2.misc_z = (nxt2.misc_res == 8'd0);
			end
		endcase
	end

	// Stage 3: decimal adjust and final flag merge
	always_comb begin
		logic [9:0] adc_s10;
		logic [7:0] s;
		adc_s10 = (d_s2.adc_s9 > BCD_HI_LIMIT) ? ({1'b0, d_s2.adc_s9} + BCD_HI_ADJ)
			: {1'b0, d_s2.adc_s9};
		s       = 8'd0;
		case (d_s2.op)
			OP_ADC: begin
				s          = d_s2.dec ? adc_s10[7:0] : d_s2.sum9[7:0];
				nxt3.result = s;
				nxt3.wb    = 1'b1;
				nxt3.cy    = d_s2.dec ? (adc_s10[9:8] != 2'd0) : d_s2.sum9[8];
				nxt3.ov    = (d_s2.a[7] ^ s[7]) & (d_s2.m[7] ^ s[7]);
				nxt3.n     = s[7];
				nxt3.z     = (s == 8'd0);
			end
			OP_SBC: begin
				s          = d_s2.dec ? d_s2.sbc_dec : d_s2.diff9[7:0];
				nxt3.result = s;
				nxt3.wb    = 1'b1;
				nxt3.cy    = !d_s2.diff9[8];
				nxt3.ov    = (d_s2.a[7] ^ d_s2.diff9[7]) & (d_s2.a[7] ^ d_s2.m[7]);
				nxt3.n     = s[7];
				nxt3.z     = (s == 8'd0);
			end
			default: begin
				nxt3.result = d_s2.misc_res;
				nxt3.wb    = d_s2.misc_wb;
				nxt3.cy    = d_s2.misc_cy;
				nxt3.ov    = d_s2.misc_ov;
				nxt3.n     = d_s2.misc_n;
				nxt3.z     = d_s2.misc_z;
			end
		endcase
	end

	// Hold or advance the stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= req.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	// Load stage payloads on transfer into each stage
	always_ff @(posedge clk) begin
		if (adv1 && req.valid) d_s1 <= nxt1;
		if (adv2 && vld_s1) d_s2 <= nxt2;
		if (adv3 && vld_s2) d_s3 <= nxt3;
	end

	assign rsp.valid        = vld_s3;
	assign rsp.result       = d_s3.result;
	assign rsp.writes_back  = d_s3.wb;
	assign rsp.carry_out    = d_s3.cy;
	assign rsp.overflow_out = d_s3.ov;
	assign rsp.negative_out = d_s3.n;
	assign rsp.zero_out     = d_s3.z;

endmodule

FILE: test/tb_eight_bit_cpu_alu_with_bcd.sv
`timescale 1ns / 1ps

module tb_eight_bit_cpu_alu_with_bcd;
	import alubcd_pkg::*;

	localparam int unsigned HALF_PERIOD    = 10;
	localparam int unsigned RESET_CYCLES   = 9;
	localparam int unsigned RANDOM_ITEMS   = 450;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 100;
	localparam int unsigned HOLD_AFTER     = 120;
	localparam int unsigned QUIET_SPAN     = 25;
	localparam int unsigned QUIET_PERIOD   = 150;

	// Unused codes behave as no operation
	localparam logic [3:0] OP_NOP_FIRST = 4'd13;
	localparam logic [3:0] OP_NOP_LAST  = 4'd15;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] reg_value;
		logic [7:0] operand;
		logic       carry_in;
		logic       overflow_in;
		logic       decimal_mode;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic       writes_back;
		logic       carry_out;
		logic       overflow_out;
		logic       negative_out;
		logic       zero_out;
	} alu_rsp_t;

	// Predict each ALU outcome and match it against the results in order
	class alu_outcome_tracker;
		alu_rsp_t    pending_outcomes[$];
		int unsigned error_count = 0;

		function alu_rsp_t compute_outcome(alu_req_t rq);
			int unsigned a, m, c, s, d, lo, hi, flagv;
			alu_rsp_t r;
			a = {24'b0, rq.reg_value};
			m = {24'b0, rq.operand};
			c = {31'b0, rq.carry_in};
			r.result       = rq.reg_value;
			r.writes_back  = 1'b1;
			r.carry_out    = rq.carry_in;
			r.overflow_out = rq.overflow_in;
			case (rq.req_type)
				OP_ADC: begin
					if (rq.decimal_mode) begin
						// Adjust the low digit into a carry at bit 4, then the high digit
						s = (a & 'h0f) + (m & 'h0f) + c;
						if (s >= 10) s = (s - 10) | 'h10;
						s = s + (a & 'hf0) + (m & 'hf0);
						if (s > 'h9f) s = s + 'h60;
					end else begin
						s = a + m + c;
					end
					r.result       = s[7:0];
					r.carry_out    = (s > 'hff);
					r.overflow_out = (((a ^ s) & (m ^ s) & 'h80) != 0);
				end
				OP_SBC: begin
					d = a - m - 1 + c;
					r.overflow_out = (((a ^ d) & (a ^ m) & 'h80) != 0);
					r.carry_out    = (d < 'h100);
					if (rq.decimal_mode) begin
						// Borrow digit by digit with a 6 adjust
						lo = (a & 'h0f) - (m & 'h0f) - 1 + c;
						hi = (a >> 4) - (m >> 4);
						if (lo & 'h10) begin
							lo = lo - 6;
							hi = hi - 1;
						end
						if (hi & 'h10) hi = hi - 6;
						r.result = {hi[3:0], lo[3:0]};
					end else begin
						r.result = d[7:0];
					end
				end
				OP_AND: r.result = rq.reg_value & rq.operand;
				OP_OR:  r.result = rq.reg_value | rq.operand;
				OP_XOR: r.result = rq.reg_value ^ rq.operand;
				OP_CMP: begin
					r.writes_back = 1'b0;
					r.carry_out   = (a >= m);
				end
				OP_BIT: begin
					r.writes_back  = 1'b0;
					r.overflow_out = rq.operand[6];
				end
				OP_ASL: begin
					r.carry_out = rq.operand[7];
					r.result    = {rq.operand[6:0], 1'b0};
				end
				OP_LSR: begin
					r.carry_out = rq.operand[0];
					r.result    = {1'b0, rq.operand[7:1]};
				end
				OP_ROL: begin
					r.carry_out = rq.operand[7];
					r.result    = {rq.operand[6:0], rq.carry_in};
				end
				OP_ROR: begin
					r.carry_out = rq.operand[0];
					r.result    = {rq.carry_in, rq.operand[7:1]};
				end
				OP_INC: r.result = rq.operand + 8'd1;
				OP_DEC: r.result = rq.operand - 8'd1;
				default: r.writes_back = 1'b0;
			endcase
			// Compare takes its flags from the difference, bit test from the operand
			if (rq.req_type == OP_CMP) flagv = (a - m) & 'hff;
			else flagv = {24'b0, r.result};
			if (rq.req_type == OP_BIT) begin
				r.negative_out = rq.operand[7];
				r.zero_out     = ((rq.operand & rq.reg_value) == 8'h00);
			end else begin
				r.negative_out = flagv[7];
				r.zero_out     = (flagv[7:0] == 8'h00);
			end
			return r;
		endfunction

		function void note_request(alu_req_t rq);
			pending_outcomes.push_back(compute_outcome(rq));
		endfunction

		function int unsigned pending();
			return pending_outcomes.size();
		endfunction

		function void check_result(alu_rsp_t got);
			alu_rsp_t exp;
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result %02h with no request outstanding", got.result);
				error_count++;
				return;
			end
			exp = pending_outcomes.pop_front();
			if (got.result !== exp.result) begin
				$error("result: expected %02h, actual %02h", exp.result, got.result);
				error_count++;
			end
			if (got.writes_back !== exp.writes_back) begin
				$error("writes_back: expected %b, actual %b", exp.writes_back, got.writes_back);
				error_count++;
			end
			if (got.carry_out !== exp.carry_out) begin
				$error("carry_out: expected %b, actual %b", exp.carry_out, got.carry_out);
				error_count++;
			end
			if (got.overflow_out !== exp.overflow_out) begin
				$error("overflow_out: expected %b, actual %b", exp.overflow_out,
					got.overflow_out);
				error_count++;
			end
			if (got.negative_out !== exp.negative_out) begin
				$error("negative_out: expected %b, actual %b", exp.negative_out,
					got.negative_out);
				error_count++;
			end
			if (got.zero_out !== exp.zero_out) begin
				$error("zero_out: expected %b, actual %b", exp.zero_out, got.zero_out);
				error_count++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	alubcd_in_if  req_if ();
	alubcd_out_if rsp_if ();

	eight_bit_cpu_alu_with_bcd u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	alu_outcome_tracker tracker = new;
	int unsigned        sent_count = 0;
	int unsigned        rsp_count  = 0;
	int unsigned        idle_cycles = 0;

	always #(HALF_PERIOD) clk = ~clk;

	// Pick a gap length: mostly none or short, now and then long
	function automatic int unsigned idle_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic alu_req_t make_req(logic [3:0] op, logic [7:0] a, logic [7:0] m,
		logic c, logic v, logic dec);
		alu_req_t rq;
		rq.req_type     = op;
		rq.reg_value    = a;
		rq.operand      = m;
		rq.carry_in     = c;
		rq.overflow_in  = v;
		rq.decimal_mode = dec;
		return rq;
	endfunction

	// Favor edge bytes and, in decimal mode, well-formed BCD bytes
	function automatic logic [7:0] random_byte(logic bcd);
		int unsigned pick;
		logic [3:0]  hi, lo;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hff;
				2: return 8'h7f;
				default: return 8'h80;
			endcase
		end
		if (bcd && pick < 60) begin
			hi = 4'($urandom_range(0, 9));
			lo = 4'($urandom_range(0, 9));
			return {hi, lo};
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic alu_req_t random_request();
		alu_req_t    rq;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6) rq.req_type = 4'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
		else if (pick < 35) rq.req_type = 4'($urandom_range(OP_ADC, OP_SBC));
		else rq.req_type = 4'($urandom_range(OP_ADC, OP_DEC));
		rq.decimal_mode = 1'($urandom_range(0, 1));
		rq.carry_in     = 1'($urandom_range(0, 1));
		rq.overflow_in  = 1'($urandom_range(0, 1));
		rq.reg_value    = random_byte(rq.decimal_mode);
		rq.operand      = random_byte(rq.decimal_mode);
		return rq;
	endfunction

	// Offer one request, wait for its transfer, then idle for a random gap
	task automatic send_request(alu_req_t rq);
		int unsigned gap;
		req_if.valid        <= 1'b1;
		req_if.req_type     <= rq.req_type;
		req_if.reg_value    <= rq.reg_value;
		req_if.operand      <= rq.operand;
		req_if.carry_in     <= rq.carry_in;
		req_if.overflow_in  <= rq.overflow_in;
		req_if.decimal_mode <= rq.decimal_mode;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		tracker.note_request(rq);
		sent_count++;
		@(negedge clk);
		gap = ((sent_count % QUIET_PERIOD) < QUIET_SPAN) ? 0 : idle_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic run_directed();
		// Binary and decimal add, including wrap and invalid digits
		send_request(make_req(OP_ADC, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_request(make_req(OP_ADC, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0));
		send_request(make_req(OP_ADC, 8'h7f, 8'h01, 1'b0, 1'b0, 1'b0));
		send_request(make_req(OP_ADC, 8'h99, 8'h01, 1'b0, 1'b0, 1'b1));
		send_request(make_req(OP_ADC, 8'h58, 8'h46, 1'b1, 1'b1, 1'b1));
		send_request(make_req(OP_ADC, 8'hff, 8'hff, 1'b1, 1'b0, 1'b1));
		// Binary and decimal subtract with borrow
		send_request(make_req(OP_SBC, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0));
		send_request(make_req(OP_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0));
		send_request(make_req(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b1));
		send_request(make_req(OP_SBC, 8'h46, 8'h12, 1'b1, 1'b0, 1'b1));
		send_request(make_req(OP_SBC, 8'hff, 8'hff, 1'b0, 1'b0, 1'b1));
		// Logic operations, compare and bit test
		send_request(make_req(OP_AND, 8'hff, 8'h00, 1'b1, 1'b1, 1'b0));
		send_request(make_req(OP_OR,  8'ha5, 8'h5a, 1'b0, 1'b0, 1'b1));
		send_request(make_req(OP_XOR, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0));
		send_request(make_req(OP_CMP, 8'h40, 8'h41, 1'b1, 1'b1, 1'b0));
		send_request(make_req(OP_CMP, 8'h80, 8'h80, 1'b0, 1'b0, 1'b1));
		send_request(make_req(OP_BIT, 8'h3f, 8'hc0, 1'b0, 1'b0, 1'b0));
		send_request(make_req(OP_BIT, 8'hff, 8'h01, 1'b1, 1'b1, 1'b0));
		// Shifts, rotates, increment, decrement and unused codes
		send_request(make_req(OP_ASL, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0));
		send_request(make_req(OP_LSR, 8'hff, 8'h01, 1'b0, 1'b1, 1'b0));
		send_request(make_req(OP_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b1));
		send_request(make_req(OP_ROR, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0));
		send_request(make_req(OP_INC, 8'h00, 8'hff, 1'b0, 1'b1, 1'b0));
		send_request(make_req(OP_DEC, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0));
		send_request(make_req(OP_NOP_FIRST, 8'h80, 8'h12, 1'b1, 1'b1, 1'b1));
		send_request(make_req(OP_NOP_LAST, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0));
	endtask

	// Drive requests, then drain and report
	initial begin
		req_if.valid        <= 1'b0;
		req_if.req_type     <= '0;
		req_if.reg_value    <= '0;
		req_if.operand      <= '0;
		req_if.carry_in     <= 1'b0;
		req_if.overflow_in  <= 1'b0;
		req_if.decimal_mode <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int i = 0; i < RANDOM_ITEMS; i++) send_request(random_request());
		req_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.error_count == 0) begin
			$display("eight_bit_cpu_alu_with_bcd test passed");
		end else begin
			$display("eight_bit_cpu_alu_with_bcd test failed");
		end
		$finish;
	end

	// Toggle ready with random stalls; hold off once for a long stretch
	initial begin
		int unsigned stall_left;
		int unsigned run_left;
		int unsigned hold_left;
		bit          held;
		stall_left = 0;
		run_left   = 0;
		hold_left  = 0;
		held       = 1'b0;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && rsp_count >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left   = $urandom_range(0, 30);
					stall_left = ((rsp_count % QUIET_PERIOD) < QUIET_SPAN) ? 0 : idle_gap();
				end
			end
		end
	end

	// Check each result transfer
	always @(posedge clk) begin
		alu_rsp_t got;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			got.result       = rsp_if.result;
			got.writes_back  = rsp_if.writes_back;
			got.carry_out    = rsp_if.carry_out;
			got.overflow_out = rsp_if.overflow_out;
			got.negative_out = rsp_if.negative_out;
			got.zero_out     = rsp_if.zero_out;
			tracker.check_result(got);
			rsp_count++;
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
			(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("eight_bit_cpu_alu_with_bcd test failed");
			$finish;
		end
	end

endmodule

FILE: sim.f
design/alubcd_pkg.sv
design/alubcd_in_if.sv
design/alubcd_out_if.sv
design/eight_bit_cpu_alu_with_bcd.sv
test/tb_eight_bit_cpu_alu_with_bcd.sv
